### src/sprc_pkg.sv
// shared types and constants for the sprite rectangle clipper
package sprc_pkg;

    localparam int DIV_STAGES = 32;
    localparam int PROD_W = 32;
    localparam int PADDR_W = 5;

    typedef enum logic [2:0] {
        REG_ENABLE = 3'd0,
        REG_LEFT   = 3'd1,
        REG_TOP    = 3'd2,
        REG_RIGHT  = 3'd3,
        REG_BOTTOM = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic signed [15:0] rect_left;
        logic signed [15:0] rect_top;
        logic signed [15:0] rect_right;
        logic signed [15:0] rect_bottom;
        logic [15:0]        tex_u_left;
        logic [15:0]        tex_u_right;
        logic [15:0]        tex_v_top;
        logic [15:0]        tex_v_bottom;
    } in_item_t;

    typedef struct packed {
        logic               visible;
        logic signed [15:0] out_left;
        logic signed [15:0] out_top;
        logic signed [15:0] out_right;
        logic signed [15:0] out_bottom;
        logic [15:0]        out_u_left;
        logic [15:0]        out_u_right;
        logic [15:0]        out_v_top;
        logic [15:0]        out_v_bottom;
    } out_item_t;

    typedef struct packed {
        logic               enable;
        logic signed [15:0] left;
        logic signed [15:0] top;
        logic signed [15:0] right;
        logic signed [15:0] bottom;
    } cfg_t;

endpackage

### src/sprc_clip_unit.sv
// one pipelined clip pass: both axes on the low side or on the high side
module sprc_clip_unit import sprc_pkg::*; #(
    parameter bit HIGH_SIDE = 1'b0
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      adv,
    input  cfg_t      cfg,
    input  logic      in_valid,
    input  out_item_t in_item,
    output logic      out_valid,
    output out_item_t out_item
);

    // setup stage
    logic             st_valid_reg;
    out_item_t        st_item_reg;
    logic             st_act_reg  [2];
    logic             st_dint_reg [2];
    logic             st_sgn_reg  [2];
    logic [15:0]      st_dm_reg   [2];
    logic [15:0]      st_nm_reg   [2];
    logic [15:0]      st_sm_reg   [2];

    // product stage is entry 0, then one quotient bit per entry
    logic              dv_valid_reg [DIV_STAGES+1];
    out_item_t         dv_item_reg  [DIV_STAGES+1];
    logic              dv_act_reg   [DIV_STAGES+1][2];
    logic              dv_dint_reg  [DIV_STAGES+1][2];
    logic              dv_sgn_reg   [DIV_STAGES+1][2];
    logic [15:0]       dv_sm_reg    [DIV_STAGES+1][2];
    logic [15:0]       dv_rem_reg   [DIV_STAGES+1][2];
    logic [PROD_W-1:0] dv_pq_reg    [DIV_STAGES+1][2];

    logic              out_valid_reg;
    out_item_t         out_item_reg;
    out_item_t         out_item_next;

    logic              act_c  [2];
    logic              dint_c [2];
    logic              sgn_c  [2];
    logic [15:0]       dm_c   [2];
    logic [15:0]       nm_c   [2];
    logic [15:0]       sm_c   [2];
    logic [15:0]       rem_next [DIV_STAGES][2];
    logic [PROD_W-1:0] pq_next  [DIV_STAGES][2];

    function automatic logic [15:0] mag17(input logic signed [16:0] x);
        logic signed [16:0] a;
        a = x[16] ? -x : x;
        return a[15:0];
    endfunction

    function automatic logic [15:0] sat16(input logic signed [34:0] x);
        logic [15:0] r;
        if (x < 0) r = 16'd0;
        else if (x > 35'sd65535) r = 16'hffff;
        else r = x[15:0];
        return r;
    endfunction

    // setup: clip condition, operands and their magnitudes
    always_comb begin
        logic signed [15:0] lo [2];
        logic signed [15:0] hi [2];
        logic signed [15:0] ce [2];
        logic [15:0]        tl [2];
        logic [15:0]        th [2];
        logic signed [16:0] sp, df, nu;
        lo[0] = in_item.out_left;  hi[0] = in_item.out_right;
        lo[1] = in_item.out_top;   hi[1] = in_item.out_bottom;
        tl[0] = in_item.out_u_left; th[0] = in_item.out_u_right;
        tl[1] = in_item.out_v_top;  th[1] = in_item.out_v_bottom;
        ce[0] = HIGH_SIDE ? cfg.right  : cfg.left;
        ce[1] = HIGH_SIDE ? cfg.bottom : cfg.top;
        for (int a = 0; a < 2; a++) begin
            sp = 17'(hi[a]) - 17'(lo[a]);
            df = $signed({1'b0, th[a]}) - $signed({1'b0, tl[a]});
            nu = HIGH_SIDE ? 17'(ce[a]) - 17'(lo[a]) : 17'(hi[a]) - 17'(ce[a]);
            act_c[a]  = in_item.visible && cfg.enable &&
                        (HIGH_SIDE ? (hi[a] > ce[a]) : (lo[a] < ce[a]));
            dint_c[a] = sp != 17'sd0;
            sgn_c[a]  = sp[16] ^ df[16] ^ nu[16];
            dm_c[a]   = mag17(df);
            nm_c[a]   = mag17(nu);
            sm_c[a]   = mag17(sp);
        end
    end

    // restoring division, one quotient bit per stage
    always_comb begin
        logic [16:0] trial;
        for (int k = 0; k < DIV_STAGES; k++) begin
            for (int a = 0; a < 2; a++) begin
                trial = {dv_rem_reg[k][a], dv_pq_reg[k][a][PROD_W-1]};
                if (trial >= {1'b0, dv_sm_reg[k][a]}) begin
                    rem_next[k][a] = 16'(trial - {1'b0, dv_sm_reg[k][a]});
                    pq_next[k][a]  = {dv_pq_reg[k][a][PROD_W-2:0], 1'b1};
                end else begin
                    rem_next[k][a] = trial[15:0];
                    pq_next[k][a]  = {dv_pq_reg[k][a][PROD_W-2:0], 1'b0};
                end
            end
        end
    end

    // apply: move the edge and re-interpolate the coordinate
    always_comb begin
        out_item_t          it;
        logic signed [34:0] qs   [2];
        logic signed [34:0] base [2];
        logic signed [34:0] res  [2];
        logic [15:0]        tv   [2];
        it = dv_item_reg[DIV_STAGES];
        base[0] = HIGH_SIDE ? 35'({19'd0, it.out_u_left}) : 35'({19'd0, it.out_u_right});
        base[1] = HIGH_SIDE ? 35'({19'd0, it.out_v_top})  : 35'({19'd0, it.out_v_bottom});
        for (int a = 0; a < 2; a++) begin
            qs[a]  = $signed({3'd0, dv_pq_reg[DIV_STAGES][a]});
            if (dv_sgn_reg[DIV_STAGES][a]) qs[a] = -qs[a];
            res[a] = HIGH_SIDE ? base[a] + qs[a] : base[a] - qs[a];
            tv[a]  = sat16(res[a]);
        end
        out_item_next = it;
        if (dv_act_reg[DIV_STAGES][0]) begin
            if (HIGH_SIDE) begin
                out_item_next.out_right = cfg.right;
                if (dv_dint_reg[DIV_STAGES][0]) out_item_next.out_u_right = tv[0];
            end else begin
                out_item_next.out_left = cfg.left;
                if (dv_dint_reg[DIV_STAGES][0]) out_item_next.out_u_left = tv[0];
            end
        end
        if (dv_act_reg[DIV_STAGES][1]) begin
            if (HIGH_SIDE) begin
                out_item_next.out_bottom = cfg.bottom;
                if (dv_dint_reg[DIV_STAGES][1]) out_item_next.out_v_bottom = tv[1];
            end else begin
                out_item_next.out_top = cfg.top;
                if (dv_dint_reg[DIV_STAGES][1]) out_item_next.out_v_top = tv[1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k <= DIV_STAGES; k++) dv_valid_reg[k] <= 1'b0;
        end else if (adv) begin
            st_valid_reg    <= in_valid;
            dv_valid_reg[0] <= st_valid_reg;
            for (int k = 0; k < DIV_STAGES; k++) dv_valid_reg[k+1] <= dv_valid_reg[k];
            out_valid_reg   <= dv_valid_reg[DIV_STAGES];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            st_item_reg    <= in_item;
            dv_item_reg[0] <= st_item_reg;
            out_item_reg   <= out_item_next;
            for (int a = 0; a < 2; a++) begin
                st_act_reg[a]  <= act_c[a];
                st_dint_reg[a] <= dint_c[a];
                st_sgn_reg[a]  <= sgn_c[a];
                st_dm_reg[a]   <= dm_c[a];
                st_nm_reg[a]   <= nm_c[a];
                st_sm_reg[a]   <= sm_c[a];
                dv_act_reg[0][a]  <= st_act_reg[a];
                dv_dint_reg[0][a] <= st_dint_reg[a];
                dv_sgn_reg[0][a]  <= st_sgn_reg[a];
                dv_sm_reg[0][a]   <= st_sm_reg[a];
                dv_rem_reg[0][a]  <= 16'd0;
                dv_pq_reg[0][a]   <= PROD_W'(st_dm_reg[a]) * PROD_W'(st_nm_reg[a]);
            end
            for (int k = 0; k < DIV_STAGES; k++) begin
                dv_item_reg[k+1] <= dv_item_reg[k];
                for (int a = 0; a < 2; a++) begin
                    dv_act_reg[k+1][a]  <= dv_act_reg[k][a];
                    dv_dint_reg[k+1][a] <= dv_dint_reg[k][a];
                    dv_sgn_reg[k+1][a]  <= dv_sgn_reg[k][a];
                    dv_sm_reg[k+1][a]   <= dv_sm_reg[k][a];
                    dv_rem_reg[k+1][a]  <= rem_next[k][a];
                    dv_pq_reg[k+1][a]   <= pq_next[k][a];
                end
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

### src/sprite_rect_clip_uv_core.sv
// sprite rectangle clipper with u/v re-interpolation, top level
//
//   channel   ports                      direction  carries
//   s_        s_valid s_ready s_item     in         one sprite with u/v per item
//   m_        m_valid m_ready m_item     out        clipped sprite and visible flag
//   apb       psel penable pwrite paddr  in         clip enable and clip rectangle
//
// one item per cycle while m_ready does not stall the pipeline; an input register, then two clip
// passes (left/top, then right/bottom) of 35 stages each, set by the 32-stage
// bit-per-stage divider in each pass.
// reset clears all valid bits; config resets to clipping off, rectangle at 0.
// a stall on m_ready holds the whole pipeline, so nothing is dropped or repeated.
module sprite_rect_clip_uv_core import sprc_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  in_item_t           s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output out_item_t          m_item,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    cfg_t      cfg_reg;
    logic      in_valid_reg;
    out_item_t in_item_reg;
    out_item_t in_item_next;
    logic      adv;
    logic      mid_valid;
    out_item_t mid_item;
    reg_idx_t  idx;

    assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (psel && penable && pwrite) begin
            unique case (idx)
                REG_ENABLE: cfg_reg.enable <= pwdata[0];
                REG_LEFT:   cfg_reg.left   <= pwdata[15:0];
                REG_TOP:    cfg_reg.top    <= pwdata[15:0];
                REG_RIGHT:  cfg_reg.right  <= pwdata[15:0];
                REG_BOTTOM: cfg_reg.bottom <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_ENABLE: prdata = {31'd0, cfg_reg.enable};
            REG_LEFT:   prdata = 32'(cfg_reg.left);
            REG_TOP:    prdata = 32'(cfg_reg.top);
            REG_RIGHT:  prdata = 32'(cfg_reg.right);
            REG_BOTTOM: prdata = 32'(cfg_reg.bottom);
            default:    prdata = 32'd0;
        endcase
    end

    // whole pipeline moves together unless the result is stuck
    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    // reject test on the raw sprite
    always_comb begin
        logic outside;
        outside = (s_item.rect_right < cfg_reg.left) || (s_item.rect_left > cfg_reg.right) ||
                  (s_item.rect_bottom < cfg_reg.top) || (s_item.rect_top > cfg_reg.bottom);
        in_item_next.visible      = !cfg_reg.enable || !outside;
        in_item_next.out_left     = s_item.rect_left;
        in_item_next.out_top      = s_item.rect_top;
        in_item_next.out_right    = s_item.rect_right;
        in_item_next.out_bottom   = s_item.rect_bottom;
        in_item_next.out_u_left   = s_item.tex_u_left;
        in_item_next.out_u_right  = s_item.tex_u_right;
        in_item_next.out_v_top    = s_item.tex_v_top;
        in_item_next.out_v_bottom = s_item.tex_v_bottom;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (adv) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            in_item_reg <= in_item_next;
        end
    end

    sprc_clip_unit #(.HIGH_SIDE(1'b0)) u_low (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .cfg       (cfg_reg),
        .in_valid  (in_valid_reg),
        .in_item   (in_item_reg),
        .out_valid (mid_valid),
        .out_item  (mid_item)
    );

    sprc_clip_unit #(.HIGH_SIDE(1'b1)) u_high (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .cfg       (cfg_reg),
        .in_valid  (mid_valid),
        .in_item   (mid_item),
        .out_valid (m_valid),
        .out_item  (m_item)
    );

endmodule

### src/sprc_checker.sv
// port-level checks for the sprite clipper, bound to the top level
module sprc_checker import sprc_pkg::*; (
    input logic      aclk,
    input logic      aresetn,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_item,
    input logic      pready
);

    // no result straight out of reset
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // a waiting result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("stalled result changed");

    // input side only stalls while a result is stuck
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("input stalled without output back pressure");

    assert property (@(posedge aclk) pready)
        else $error("config port not ready");

endmodule

bind sprite_rect_clip_uv_core sprc_checker u_sprc_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item),
    .pready  (pready)
);

### verif/tb_sprite_rect_clip_uv_core.sv
// self-checking testbench for the sprite rectangle clipper with u/v re-interpolation
module tb_sprite_rect_clip_uv_core;
    import sprc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = 71;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    in_item_t s_item;
    logic m_valid;
    logic m_ready;
    out_item_t m_item;
    logic psel;
    logic penable;
    logic pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    sprite_rect_clip_uv_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_item(s_item),
        .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    cfg_t clip_cfg;
    out_item_t clipped_q[$];
    int errors = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_cycles = 0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #100ms;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic logic [15:0] sat_tex(longint v);
        if (v < 0) return 16'd0;
        if (v > 65535) return 16'hffff;
        return v[15:0];
    endfunction

    // proportional shift of one texture coordinate, quotient truncated toward zero
    function automatic longint lerp_delta(longint d, longint n, longint s);
        return (d * n) / s;
    endfunction

    function automatic out_item_t clip_sprite(in_item_t it, cfg_t c);
        out_item_t o;
        longint l, t, r, b, ul, ur, vt, vb, cl, ct, cr, cb;
        l = it.rect_left; t = it.rect_top; r = it.rect_right; b = it.rect_bottom;
        ul = it.tex_u_left; ur = it.tex_u_right; vt = it.tex_v_top; vb = it.tex_v_bottom;
        cl = c.left; ct = c.top; cr = c.right; cb = c.bottom;
        o.visible = 1'b1;
        if (c.enable) begin
            if (r < cl || l > cr || b < ct || t > cb) begin
                o.visible = 1'b0;
            end else begin
                if (l < cl) begin
                    if (r != l) ul = sat_tex(ur - lerp_delta(ur - ul, r - cl, r - l));
                    l = cl;
                end
                if (t < ct) begin
                    if (b != t) vt = sat_tex(vb - lerp_delta(vb - vt, b - ct, b - t));
                    t = ct;
                end
                if (r > cr) begin
                    if (r != l) ur = sat_tex(ul + lerp_delta(ur - ul, cr - l, r - l));
                    r = cr;
                end
                if (b > cb) begin
                    if (b != t) vb = sat_tex(vt + lerp_delta(vb - vt, cb - t, b - t));
                    b = cb;
                end
            end
        end
        o.out_left = l[15:0]; o.out_top = t[15:0];
        o.out_right = r[15:0]; o.out_bottom = b[15:0];
        o.out_u_left = ul[15:0]; o.out_u_right = ur[15:0];
        o.out_v_top = vt[15:0]; o.out_v_bottom = vb[15:0];
        return o;
    endfunction

    // receiver: random stalls, plus a long hold-off when requested
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        out_item_t exp_item;
        if (aresetn && m_valid && m_ready) begin
            if (clipped_q.size() == 0) begin
                $display("%0t: unexpected item %h", $time, m_item);
                errors++;
            end else begin
                exp_item = clipped_q.pop_front();
                if (m_item.visible !== exp_item.visible ||
                    m_item.out_left !== exp_item.out_left ||
                    m_item.out_top !== exp_item.out_top ||
                    m_item.out_right !== exp_item.out_right ||
                    m_item.out_bottom !== exp_item.out_bottom ||
                    m_item.out_u_left !== exp_item.out_u_left ||
                    m_item.out_u_right !== exp_item.out_u_right ||
                    m_item.out_v_top !== exp_item.out_v_top ||
                    m_item.out_v_bottom !== exp_item.out_v_bottom) begin
                    $display("%0t: mismatch expected %h actual %h", $time, exp_item, m_item);
                    errors++;
                end
            end
        end
    end

    // valid stays up between back-to-back items; idle cycles and drain() drop it
    task automatic send_sprite(in_item_t it);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item <= it;
        clipped_q.push_back(clip_sprite(it, clip_cfg));
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [15:0] val);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= PADDR_W'(4 * idx); pwdata <= {16'd0, val};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        case (idx)
            REG_ENABLE: clip_cfg.enable = val[0];
            REG_LEFT: clip_cfg.left = val;
            REG_TOP: clip_cfg.top = val;
            REG_RIGHT: clip_cfg.right = val;
            default: clip_cfg.bottom = val;
        endcase
    endtask

    task automatic drain();
        int n;
        n = 0;
        s_valid <= 1'b0;
        while (clipped_q.size() != 0 && n < 200000) begin
            @(posedge aclk);
            n++;
        end
        if (clipped_q.size() != 0) begin
            $display("*** FAILED ***");
            $finish;
        end
        repeat (LATENCY + 5) @(posedge aclk);
    endtask

    task automatic set_clip(logic en, int l, int t, int r, int b);
        drain();
        write_reg(REG_ENABLE, {15'd0, en});
        write_reg(REG_LEFT, l[15:0]);
        write_reg(REG_TOP, t[15:0]);
        write_reg(REG_RIGHT, r[15:0]);
        write_reg(REG_BOTTOM, b[15:0]);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    function automatic in_item_t make_sprite(int l, int t, int r, int b,
                                             int ul, int ur, int vt, int vb);
        in_item_t it;
        it.rect_left = l[15:0]; it.rect_top = t[15:0];
        it.rect_right = r[15:0]; it.rect_bottom = b[15:0];
        it.tex_u_left = ul[15:0]; it.tex_u_right = ur[15:0];
        it.tex_v_top = vt[15:0]; it.tex_v_bottom = vb[15:0];
        return it;
    endfunction

    // edge values mostly near the clip rectangle so that clipping is exercised
    function automatic int near_edge(int lo, int hi);
        case ($urandom_range(3))
            0: return $urandom_range(65535) - 32768;
            1: return lo + $urandom_range(80) - 40;
            2: return hi + $urandom_range(80) - 40;
            default: return lo + int'($urandom_range(hi > lo ? hi - lo : 0));
        endcase
    endfunction

    function automatic in_item_t rand_sprite();
        int l, t, r, b;
        if ($urandom_range(9) == 0) begin
            return make_sprite($urandom, $urandom, $urandom, $urandom,
                               $urandom, $urandom, $urandom, $urandom);
        end
        l = near_edge(clip_cfg.left, clip_cfg.right);
        r = near_edge(clip_cfg.left, clip_cfg.right);
        t = near_edge(clip_cfg.top, clip_cfg.bottom);
        b = near_edge(clip_cfg.top, clip_cfg.bottom);
        if (l > r && $urandom_range(3) != 0) begin
            l = l ^ r; r = l ^ r; l = l ^ r;
        end
        if (t > b && $urandom_range(3) != 0) begin
            t = t ^ b; b = t ^ b; t = t ^ b;
        end
        if (l < -32768) l = -32768;
        if (r > 32767) r = 32767;
        if (t < -32768) t = -32768;
        if (b > 32767) b = 32767;
        return make_sprite(l, t, r, b, $urandom, $urandom, $urandom, $urandom);
    endfunction

    task automatic test_passthrough();
        set_clip(1'b0, 0, 0, 0, 0);
        send_sprite(make_sprite(-32768, -32768, 32767, 32767, 0, 65535, 65535, 0));
        send_sprite(make_sprite(32767, 32767, -32768, -32768, 65535, 0, 0, 65535));
    endtask

    task automatic test_directed_clips();
        set_clip(1'b1, -100, -50, 100, 50);
        // wholly outside on each side
        send_sprite(make_sprite(-300, 0, -101, 10, 1, 2, 3, 4));
        send_sprite(make_sprite(101, 0, 300, 10, 1, 2, 3, 4));
        send_sprite(make_sprite(0, -300, 10, -51, 1, 2, 3, 4));
        send_sprite(make_sprite(0, 51, 10, 300, 1, 2, 3, 4));
        // touching the edges, fully inside
        send_sprite(make_sprite(-100, -50, 100, 50, 0, 65535, 0, 65535));
        // clipped on every side, both directions of u and v
        send_sprite(make_sprite(-32768, -32768, 32767, 32767, 0, 65535, 65535, 0));
        send_sprite(make_sprite(-200, -60, 150, 70, 65535, 0, 0, 65535));
        send_sprite(make_sprite(-101, -51, 101, 51, 16384, 16385, 7, 9));
        // degenerate sprite: left equals right
        send_sprite(make_sprite(-100, -50, -100, -50, 100, 200, 300, 400));
        // inverted clip rectangle: zero span and saturation
        set_clip(1'b1, 20, 20, -20, -20);
        send_sprite(make_sprite(-20, -20, 20, 20, 0, 65535, 65535, 0));
        send_sprite(make_sprite(-30, -25, 25, 30, 65535, 0, 0, 65535));
        send_sprite(make_sprite(-20, -20, -20, -20, 5, 6, 7, 8));
        send_sprite(make_sprite(-32768, -32768, 32767, 32767, 0, 65535, 0, 65535));
        set_clip(1'b1, -32768, -32768, 32767, 32767);
        send_sprite(make_sprite(-32768, -32768, 32767, 32767, 1, 2, 3, 4));
        set_clip(1'b1, 32767, 32767, -32768, -32768);
        send_sprite(make_sprite(-32768, -32768, 32767, 32767, 0, 65535, 65535, 0));
        send_sprite(make_sprite(32767, 32767, 32767, 32767, 0, 65535, 65535, 0));
    endtask

    task automatic test_random_phase(int n, int idle, int stall);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        repeat (n) send_sprite(rand_sprite());
    endtask

    task automatic test_random_clips();
        set_clip(1'b1, -100, -80, 120, 90);
        test_random_phase(150, 0, 0);
        set_clip(1'b1, $urandom, $urandom, $urandom, $urandom);
        test_random_phase(150, 66, 0);
        set_clip(1'b1, -32768, 5, 32767, 5);
        test_random_phase(150, 0, 66);
        set_clip(1'b1, 500, -700, -500, 700);
        test_random_phase(150, 31, 31);
        set_clip(1'b0, $urandom, $urandom, $urandom, $urandom);
        test_random_phase(100, 31, 31);
    endtask

    task automatic test_backpressure();
        set_clip(1'b1, -50, -50, 50, 50);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles <= 300;
        test_random_phase(150, 0, 0);
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_item = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        clip_cfg = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_passthrough();
        test_directed_clips();
        test_random_clips();
        test_backpressure();
        drain();
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

### sim.f
src/sprc_pkg.sv
src/sprc_clip_unit.sv
src/sprite_rect_clip_uv_core.sv
src/sprc_checker.sv
verif/tb_sprite_rect_clip_uv_core.sv
